// ===== hdl/bellman_ford_difference_constraints_defines.svh =====
// ---------------------------------------------------------------------------
// bellman_ford_difference_constraints_defines
// assertion macros used by the checker file of the solver
// ---------------------------------------------------------------------------
`ifndef BELLMAN_FORD_DIFFERENCE_CONSTRAINTS_DEFINES_SVH
`define BELLMAN_FORD_DIFFERENCE_CONSTRAINTS_DEFINES_SVH

// property sampled on clk, off while arst_n is low
`define BFDC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// a request that is stalled keeps its signal stable
`define BFDC_ASSERT_HOLD(label, vld, stl, sig, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		((vld) && (stl)) |=> $stable(sig)) else $error(msg);

`endif

// ===== hdl/bfdc_pkg.sv =====
// ---------------------------------------------------------------------------
// bfdc_pkg
// types and constants of the difference constraint solver
// ---------------------------------------------------------------------------
`default_nettype none

package bfdc_pkg;

	localparam int DEF_MAX_NODES = 256;
	localparam int DEF_MAX_EDGES = 1024;
	localparam int DEF_COST_BITS = 32;

	localparam int NODE_COUNT_W = 9;
	localparam logic [NODE_COUNT_W-1:0] NODE_COUNT_RESET = 9'd256;

	localparam logic signed [63:0] DIST_INIT = 64'sd2000000000000000000;
	localparam logic signed [63:0] DIST_MAX  = 64'sh7fff_ffff_ffff_ffff;
	localparam logic signed [63:0] DIST_MIN  = 64'sh8000_0000_0000_0000;

	typedef enum logic [1:0] {
		OP_ADD_LE    = 2'd0,
		OP_ADD_GE    = 2'd1,
		OP_QUERY_MAX = 2'd2,
		OP_QUERY_MIN = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_Q_START,
		ST_E1,
		ST_E2,
		ST_E3,
		ST_ANS_RD,
		ST_ANS,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic signed [63:0] value;
		logic               negative_cycle;
		logic               table_full;
	} result_t;

endpackage

`default_nettype wire

// ===== hdl/bfdc_ram.sv =====
// ---------------------------------------------------------------------------
// bfdc_ram
// generic single write, single read RAM with registered read data
// ---------------------------------------------------------------------------
`default_nettype none

module bfdc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== hdl/bellman_ford_difference_constraints.sv =====
// ---------------------------------------------------------------------------
// bellman_ford_difference_constraints
// difference constraint solver: edge table plus Bellman-Ford relaxation
// ---------------------------------------------------------------------------
// Add requests store one edge unless the edge table is full; they keep
// streaming one per cycle while the output register is free. A query runs at
// most node_count sweeps over the edges; each edge takes three steps (E1, E2,
// E3) on the single read port of the distance RAM (read dist(from), read
// dist(to), compare and write back), with one shared 64-bit saturating adder
// and comparator. Distances persist between queries. After reset a clearing
// pass over all MAX_NODES entries loads every distance with 2e18; no request
// is taken during it, configuration writes are.
// ---------------------------------------------------------------------------
`default_nettype none

module bellman_ford_difference_constraints #(
	parameter int MAX_NODES = bfdc_pkg::DEF_MAX_NODES,
	parameter int MAX_EDGES = bfdc_pkg::DEF_MAX_EDGES,
	parameter int COST_BITS = bfdc_pkg::DEF_COST_BITS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wr_en,
	input  logic [bfdc_pkg::NODE_COUNT_W-1:0]     cfg_wr_data,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [1:0]                            op,
	input  logic [7:0]                            node_a,
	input  logic [7:0]                            node_b,
	input  logic signed [31:0]                    cost,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [63:0]                    value,
	output logic                                  negative_cycle,
	output logic                                  table_full
);

	import bfdc_pkg::*;

	localparam int NODE_W = $clog2(MAX_NODES);
	localparam int EA_W   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int EC_W   = $clog2(MAX_EDGES + 1);
	localparam int EW     = 2 * NODE_W + COST_BITS;
	localparam int CW     = ((COST_BITS > 33) ? COST_BITS : 33) + 1;
	localparam logic signed [CW-1:0] CMAX = (CW'(1) <<< (COST_BITS - 1)) - CW'(1);
	localparam logic signed [CW-1:0] CMIN = -CMAX - CW'(1);

	state_t state_q, state_d;

	logic [NODE_W-1:0]       clr_q;
	logic [NODE_COUNT_W-1:0] node_count_q;
	logic [EC_W-1:0]         edge_count_q;
	logic [EA_W-1:0]         edge_idx_q;
	logic [NODE_COUNT_W-1:0] sweep_q;
	logic                    changed_q;
	logic                    out_valid_q;

	logic [NODE_W-1:0]  start_q, target_q;
	logic               is_min_q;
	logic signed [63:0] cand_q;
	result_t            res_q, out_q;

	logic [NODE_W-1:0] node_mod [256];

	logic              e_we;
	logic [EA_W-1:0]   e_waddr, e_raddr;
	logic [EW-1:0]     e_wdata, e_rdata;
	logic              d_we;
	logic [NODE_W-1:0] d_waddr, d_raddr;
	logic [63:0]       d_wdata, d_rdata;

	op_t                   op_c;
	logic                  in_fire, is_add, is_full, out_free, load_out;
	logic [NODE_W-1:0]     idx_a, idx_b;
	logic signed [CW-1:0]  cost_w, cost_n, cost_pick;
	logic [COST_BITS-1:0]  cost_sat;
	logic [NODE_W-1:0]     e_src, e_dst;
	logic [COST_BITS-1:0]  e_w;
	logic signed [63:0]    w64, d_cur, sat_sum, answer;
	logic signed [64:0]    sum65;
	logic                  better, chg, last, sweep_end;
	result_t               add_res, neg_res, out_d;

	for (genvar g = 0; g < 256; g++) begin : g_mod
		assign node_mod[g] = NODE_W'(g % MAX_NODES);
	end

	bfdc_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_edge_ram (
		.clk   (clk),
		.we    (e_we),
		.waddr (e_waddr),
		.wdata (e_wdata),
		.raddr (e_raddr),
		.rdata (e_rdata)
	);

	bfdc_ram #(.WIDTH(64), .DEPTH(MAX_NODES)) u_dist_ram (
		.clk   (clk),
		.we    (d_we),
		.waddr (d_waddr),
		.wdata (d_wdata),
		.raddr (d_raddr),
		.rdata (d_rdata)
	);

	// request decode
	assign op_c     = op_t'(op);
	assign in_stall = (state_q != ST_IDLE);
	assign in_fire  = in_valid && !in_stall;
	assign is_add   = (op_c == OP_ADD_LE) || (op_c == OP_ADD_GE);
	assign is_full  = (edge_count_q == EC_W'(MAX_EDGES));
	assign out_free = !out_valid_q || !out_stall;
	assign idx_a    = node_mod[node_a];
	assign idx_b    = node_mod[node_b];

	// stored weight saturates to the cost range
	assign cost_w    = {{(CW-32){cost[31]}}, cost};
	assign cost_n    = -cost_w;
	assign cost_pick = (op_c == OP_ADD_LE) ? cost_w : cost_n;
	always_comb begin
		if (cost_pick > CMAX) begin
			cost_sat = CMAX[COST_BITS-1:0];
		end else if (cost_pick < CMIN) begin
			cost_sat = CMIN[COST_BITS-1:0];
		end else begin
			cost_sat = cost_pick[COST_BITS-1:0];
		end
	end

	// shared relaxation unit
	assign e_src     = e_rdata[EW-1 -: NODE_W];
	assign e_dst     = e_rdata[COST_BITS +: NODE_W];
	assign e_w       = e_rdata[COST_BITS-1:0];
	assign w64       = {{(64-COST_BITS){e_w[COST_BITS-1]}}, e_w};
	assign d_cur     = d_rdata;
	assign sum65     = {d_cur[63], d_cur} + {w64[63], w64};
	assign sat_sum   = (sum65[64] ^ sum65[63]) ? (sum65[64] ? DIST_MIN : DIST_MAX)
	                                           : sum65[63:0];
	assign better    = (cand_q < d_cur);
	assign chg       = changed_q || better;
	assign last      = ((EC_W'(edge_idx_q) + EC_W'(1)) == edge_count_q);
	assign sweep_end = (({1'b0, sweep_q} + (NODE_COUNT_W+1)'(1)) == {1'b0, node_count_q});

	assign answer = !is_min_q ? d_cur : ((d_cur == DIST_MIN) ? DIST_MAX : -d_cur);

	assign add_res = '{value: '0, negative_cycle: 1'b0, table_full: is_full};
	assign neg_res = '{value: '0, negative_cycle: 1'b1, table_full: 1'b0};

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == NODE_W'(MAX_NODES - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_fire) begin
					if (is_add) state_d = out_free ? ST_IDLE : ST_DONE;
					else        state_d = ST_Q_START;
				end
			end
			ST_Q_START: begin
				if (edge_count_q == '0)      state_d = ST_ANS_RD;
				else if (node_count_q == '0) state_d = ST_DONE;
				else                         state_d = ST_E1;
			end
			ST_E1: state_d = ST_E2;
			ST_E2: state_d = ST_E3;
			ST_E3: begin
				if (!last)          state_d = ST_E1;
				else if (!chg)      state_d = ST_ANS_RD;
				else if (sweep_end) state_d = ST_DONE;
				else                state_d = ST_E1;
			end
			ST_ANS_RD: state_d = ST_ANS;
			ST_ANS:    state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// memory controls and output load
	always_comb begin
		e_we     = 1'b0;
		e_waddr  = edge_count_q[EA_W-1:0];
		e_wdata  = (op_c == OP_ADD_LE) ? {idx_a, idx_b, cost_sat} : {idx_b, idx_a, cost_sat};
		e_raddr  = edge_idx_q;
		d_we     = 1'b0;
		d_waddr  = e_dst;
		d_wdata  = cand_q;
		d_raddr  = e_src;
		load_out = 1'b0;
		out_d    = res_q;
		case (state_q)
			ST_CLEAR: begin
				d_we    = 1'b1;
				d_waddr = clr_q;
				d_wdata = DIST_INIT;
			end
			ST_IDLE: begin
				if (in_fire && is_add) begin
					e_we     = !is_full;
					load_out = out_free;
					out_d    = add_res;
				end
			end
			ST_Q_START: begin
				d_we    = 1'b1;
				d_waddr = start_q;
				d_wdata = '0;
				e_raddr = '0;
			end
			ST_E1: d_raddr = e_src;
			ST_E2: d_raddr = e_dst;
			ST_E3: begin
				d_we    = better;
				e_raddr = last ? '0 : edge_idx_q + EA_W'(1);
			end
			ST_ANS_RD: d_raddr = target_q;
			ST_ANS:    d_raddr = target_q;
			ST_DONE:   load_out = out_free;
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			node_count_q <= NODE_COUNT_RESET;
			edge_count_q <= '0;
			edge_idx_q   <= '0;
			sweep_q      <= '0;
			changed_q    <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) node_count_q <= cfg_wr_data;
			if (load_out) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: clr_q <= clr_q + NODE_W'(1);
				ST_IDLE: begin
					if (in_fire && is_add && !is_full) edge_count_q <= edge_count_q + EC_W'(1);
				end
				ST_Q_START: begin
					edge_idx_q <= '0;
					sweep_q    <= '0;
					changed_q  <= 1'b0;
				end
				ST_E3: begin
					if (!last) begin
						edge_idx_q <= edge_idx_q + EA_W'(1);
						changed_q  <= chg;
					end else begin
						edge_idx_q <= '0;
						changed_q  <= 1'b0;
						sweep_q    <= sweep_q + NODE_COUNT_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (load_out) out_q <= out_d;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					res_q    <= add_res;
					start_q  <= (op_c == OP_QUERY_MAX) ? idx_a : idx_b;
					target_q <= (op_c == OP_QUERY_MAX) ? idx_b : idx_a;
					is_min_q <= (op_c == OP_QUERY_MIN);
				end
			end
			ST_Q_START: begin
				if (edge_count_q != '0 && node_count_q == '0) res_q <= neg_res;
			end
			ST_E2: cand_q <= sat_sum;
			ST_E3: begin
				if (last && chg && sweep_end) res_q <= neg_res;
			end
			ST_ANS: res_q <= '{value: answer, negative_cycle: 1'b0, table_full: 1'b0};
			default: begin
			end
		endcase
	end

	assign out_valid      = out_valid_q;
	assign value          = out_q.value;
	assign negative_cycle = out_q.negative_cycle;
	assign table_full     = out_q.table_full;

endmodule

`default_nettype wire

// ===== hdl/bfdc_checker.sv =====
// ---------------------------------------------------------------------------
// bfdc_checker
// port level checks on the result channel of the solver
// ---------------------------------------------------------------------------
`default_nettype none

`include "bellman_ford_difference_constraints_defines.svh"

module bfdc_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [63:0] value,
	input  logic               negative_cycle,
	input  logic               table_full
);

	// a stalled result stays valid and keeps its value
	`BFDC_ASSERT(a_out_valid_holds, (out_valid && out_stall) |=> out_valid, "result dropped")
	`BFDC_ASSERT_HOLD(a_out_value_holds, out_valid, out_stall, value, "value changed")

	// a negative cycle carries no answer and never comes with an add flag
	`BFDC_ASSERT(a_negcyc_no_value, (out_valid && negative_cycle) |-> (value == '0),
		"value on negative cycle")
	`BFDC_ASSERT(a_flags_exclusive, out_valid |-> !(negative_cycle && table_full),
		"both flags set")

endmodule

bind bellman_ford_difference_constraints bfdc_checker u_checker (.*);

`default_nettype wire
